FILE: hdl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants of the periodic frame scheduler.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int OP_W     = 3;
  localparam int TIME_W   = 48;
  localparam int ID_W     = 29;
  localparam int CH_W     = 8;
  localparam int KIND_W   = 3;
  localparam int PERIOD_W = 32;
  localparam int LEN_W    = 4;
  localparam int PAY_W    = 64;
  localparam int DUE_W    = 49;
  localparam int STAMP_W  = 52;
  localparam int CNT_W    = 6;

  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD      = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd3;
  localparam logic [OP_W-1:0] OP_REANCHOR = 3'd4;

  localparam logic [0:0] CFG_FD_KIND_A = 1'b0;
  localparam logic [0:0] CFG_FD_KIND_B = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_EMIT,
    ST_SHIFT,
    ST_STATUS
  } state_t;

  // one task entry as stored
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [CH_W-1:0]     channel;
    logic [KIND_W-1:0]   kind;
    logic [PERIOD_W-1:0] period;
    logic                active;
    logic [LEN_W-1:0]    length;
    logic [PAY_W-1:0]    payload;
    logic [DUE_W-1:0]    due;
  } task_t;

endpackage

FILE: hdl/pfs_due_unit.sv
// ----------------------------------------------------------------------------
// pfs_due_unit
// Shared 49-bit adder and compare used for anchoring and advancing due times.
// ----------------------------------------------------------------------------
module pfs_due_unit (
  input  logic [pfs_pkg::DUE_W-1:0]    base,
  input  logic [pfs_pkg::PERIOD_W-1:0] period,
  input  logic [pfs_pkg::TIME_W-1:0]   now,
  output logic [pfs_pkg::DUE_W-1:0]    sum,
  output logic                         is_due
);

  assign sum    = base + {{(pfs_pkg::DUE_W-pfs_pkg::PERIOD_W){1'b0}}, period};
  assign is_due = (base <= {1'b0, now});

endmodule

FILE: hdl/periodic_frame_scheduler_top.sv
// ----------------------------------------------------------------------------
// periodic_frame_scheduler_top
// Ordered table of periodic transmit tasks, walked one entry at a time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in_     | input     | in_valid / in_stall (driven here)
//  out_    | output    | out_valid / out_stall (driven by sink)
//  cfg_    | input     | cfg_valid / cfg_ready
//
// one word is taken at a time; the table lives in a memory with one read port
// tick: each task passes through read, eval and emit, where its frames are issued; then a status word
// remove: entries are scanned through read, eval and emit; each entry moved up passes through shift
// add, clear, re-anchor: taken in idle, then a status word; re-anchor clears every anchored flag
// reset clears control state only; the table needs no clearing pass
// a stalled result holds the sequencer in place
module periodic_frame_scheduler_top #(
  parameter int MAX_TASKS   = 16,
  parameter int MAX_CATCHUP = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfs_pkg::OP_W-1:0]      in_operation,
  input  logic [pfs_pkg::TIME_W-1:0]    in_current_time,
  input  logic [pfs_pkg::ID_W-1:0]      in_frame_id,
  input  logic [pfs_pkg::CH_W-1:0]      in_bus_channel,
  input  logic [pfs_pkg::KIND_W-1:0]    in_bus_kind,
  input  logic [pfs_pkg::PERIOD_W-1:0]  in_repeat_period,
  input  logic                          in_active,
  input  logic [pfs_pkg::LEN_W-1:0]     in_length_code,
  input  logic [pfs_pkg::PAY_W-1:0]     in_payload,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_frame,
  output logic [pfs_pkg::KIND_W-1:0]    out_out_kind,
  output logic [pfs_pkg::CH_W-1:0]      out_out_channel,
  output logic [pfs_pkg::ID_W-1:0]      out_out_id,
  output logic                          out_fd_flag,
  output logic [pfs_pkg::LEN_W-1:0]     out_out_length,
  output logic [pfs_pkg::PAY_W-1:0]     out_out_payload,
  output logic [pfs_pkg::STAMP_W-1:0]   out_stamp,
  output logic                          out_success,
  output logic [pfs_pkg::CNT_W-1:0]     out_emitted_count,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [0:0]                    cfg_index,
  input  logic [2:0]                    cfg_data
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TC_W  = $clog2(MAX_TASKS + 1);
  localparam int K_W   = $clog2(MAX_CATCHUP + 1);

  pfs_pkg::state_t state_r, state_nxt;

  pfs_pkg::task_t mem [MAX_TASKS];
  // anchored flag per entry; entry due counts as zero while its flag is clear
  logic [MAX_TASKS-1:0] anch_r;

  logic [TC_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [pfs_pkg::CNT_W-1:0] emit_r, emit_nxt;
  logic             succ_r, succ_nxt;
  logic [2:0]       kind_a_r, kind_b_r;

  logic [pfs_pkg::OP_W-1:0]   op_r;
  logic [pfs_pkg::TIME_W-1:0] now_r;
  logic [pfs_pkg::ID_W-1:0]   id_r;
  logic [pfs_pkg::CH_W-1:0]   ch_r;
  logic [pfs_pkg::STAMP_W-1:0] stamp_r;

  pfs_pkg::task_t rd_r, ent_r, ent_nxt;
  logic           ent_cur_r;

  // memory port controls
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  pfs_pkg::task_t       mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic                 mem_re;

  logic [pfs_pkg::DUE_W-1:0] du_base, du_sum;
  logic                      du_due;
  logic [pfs_pkg::DUE_W-1:0] due_eff;

  logic in_acc, out_acc, ov_r, ov_nxt, res_frame_nxt, res_last_nxt;
  logic res_frame_r, res_last_r;
  logic [TC_W-1:0] idx_ext;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != pfs_pkg::ST_IDLE);
  assign out_acc  = ov_r && !out_stall;
  assign cfg_ready = 1'b1;
  assign idx_ext  = TC_W'(idx_r);
  assign due_eff  = ent_cur_r ? ent_r.due : '0;

  pfs_due_unit u_due (
    .base   (du_base),
    .period (ent_r.period),
    .now    (now_r),
    .sum    (du_sum),
    .is_due (du_due)
  );

  always_comb begin
    du_base = due_eff;
    if (due_eff == '0) begin
      du_base = {1'b0, now_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pfs_pkg::ST_IDLE;
      count_r  <= '0;
      ov_r     <= 1'b0;
      kind_a_r <= 3'd1;
      kind_b_r <= 3'd2;
      anch_r   <= '0;
      k_r      <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      k_r     <= k_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pfs_pkg::CFG_FD_KIND_A) begin
          kind_a_r <= cfg_data;
        end else begin
          kind_b_r <= cfg_data;
        end
      end
      if (mem_we) begin
        anch_r[mem_waddr] <= 1'b1;
      end
      if (in_acc && in_operation == pfs_pkg::OP_REANCHOR) begin
        anch_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    emit_r      <= emit_nxt;
    succ_r      <= succ_nxt;
    ent_r       <= ent_nxt;
    res_frame_r <= res_frame_nxt;
    res_last_r  <= res_last_nxt;
    if (state_r == pfs_pkg::ST_READ) begin
      ent_cur_r <= anch_r[idx_r];
    end
    if (in_acc) begin
      op_r    <= in_operation;
      now_r   <= in_current_time;
      id_r    <= in_frame_id;
      ch_r    <= in_bus_channel;
      // times ten as two shifts and an add
      stamp_r <= ({4'd0, in_current_time} << 3) + ({4'd0, in_current_time} << 1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    emit_nxt      = emit_r;
    succ_nxt      = succ_r;
    ent_nxt       = ent_r;
    ov_nxt        = ov_r && out_stall;
    res_frame_nxt = res_frame_r;
    res_last_nxt  = res_last_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = ent_r;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;
    case (state_r)
      pfs_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_nxt  = '0;
          emit_nxt = '0;
          succ_nxt = 1'b0;
          state_nxt = pfs_pkg::ST_STATUS;
          case (in_operation)
            pfs_pkg::OP_TICK, pfs_pkg::OP_REMOVE: begin
              if (count_r != '0) begin
                state_nxt = pfs_pkg::ST_READ;
              end
            end
            pfs_pkg::OP_ADD: begin
              if (count_r < TC_W'(MAX_TASKS)) begin
                mem_we    = 1'b1;
                mem_waddr = count_r[IDX_W-1:0];
                mem_wdata = '{id: in_frame_id, channel: in_bus_channel,
                              kind: in_bus_kind, period: in_repeat_period,
                              active: in_active, length: in_length_code,
                              payload: in_payload, due: '0};
                count_nxt = count_r + 1'b1;
                succ_nxt  = 1'b1;
              end
            end
            pfs_pkg::OP_CLEAR: count_nxt = '0;
            default: ;
          endcase
        end
      end
      pfs_pkg::ST_READ: begin
        mem_re    = 1'b1;
        k_nxt     = '0;
        state_nxt = pfs_pkg::ST_EVAL;
      end
      pfs_pkg::ST_EVAL: begin
        // first cycle after the read, take the entry from the read register
        ent_nxt   = rd_r;
        state_nxt = pfs_pkg::ST_EMIT;
      end
      pfs_pkg::ST_EMIT: begin
        if (!ov_r || !out_stall) begin
          if (op_r == pfs_pkg::OP_REMOVE) begin
            if (ent_r.id == id_r && ent_r.channel == ch_r) begin
              succ_nxt = 1'b1;
              if (idx_ext + 1'b1 < count_r) begin
                mem_re    = 1'b1;
                mem_raddr = idx_r + 1'b1;
                state_nxt = pfs_pkg::ST_SHIFT;
              end else begin
                count_nxt = count_r - 1'b1;
                state_nxt = pfs_pkg::ST_STATUS;
              end
            end else if (idx_ext + 1'b1 < count_r) begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = pfs_pkg::ST_READ;
            end else begin
              state_nxt = pfs_pkg::ST_STATUS;
            end
          end else begin
            if (ent_r.active && ent_r.period != '0 && due_eff == '0 &&
                !(ent_cur_r && ent_r.due != '0)) begin
              ent_nxt.due = du_sum;
              mem_we      = 1'b1;
              mem_wdata   = ent_nxt;
              if (idx_ext + 1'b1 < count_r) begin
                idx_nxt   = idx_r + 1'b1;
                state_nxt = pfs_pkg::ST_READ;
              end else begin
                state_nxt = pfs_pkg::ST_STATUS;
              end
            end else if (ent_r.active && ent_r.period != '0 && du_due &&
                         k_r < K_W'(MAX_CATCHUP)) begin
              ov_nxt        = 1'b1;
              res_frame_nxt = 1'b1;
              res_last_nxt  = 1'b0;
              emit_nxt      = emit_r + 1'b1;
              k_nxt         = k_r + 1'b1;
              ent_nxt.due   = du_sum;
              mem_we        = 1'b1;
              mem_wdata     = ent_nxt;
            end else if (idx_ext + 1'b1 < count_r) begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = pfs_pkg::ST_READ;
            end else begin
              state_nxt = pfs_pkg::ST_STATUS;
            end
          end
        end
      end
      pfs_pkg::ST_SHIFT: begin
        // copy entry idx+1 down into idx, then continue from idx+1
        mem_we    = 1'b1;
        mem_wdata = rd_r;
        mem_wdata.due = anch_r[idx_r + 1'b1] ? rd_r.due : '0;
        idx_nxt   = idx_r + 1'b1;
        if (idx_ext + 2'd2 < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + 2'd2;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = pfs_pkg::ST_STATUS;
        end
      end
      pfs_pkg::ST_STATUS: begin
        if (!ov_r || !out_stall) begin
          ov_nxt        = 1'b1;
          res_frame_nxt = 1'b0;
          res_last_nxt  = 1'b1;
          state_nxt     = pfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pfs_pkg::ST_IDLE;
    endcase
  end

  // frame fields come from the entry still held in ent_r
  logic [pfs_pkg::KIND_W-1:0] fk_r;
  logic [pfs_pkg::CH_W-1:0]   fch_r;
  logic [pfs_pkg::ID_W-1:0]   fid_r;
  logic [pfs_pkg::LEN_W-1:0]  flen_r;
  logic [pfs_pkg::PAY_W-1:0]  fpay_r;
  logic                       ffd_r;
  logic                       fsucc_r;
  logic [pfs_pkg::CNT_W-1:0]  fcnt_r;

  always_ff @(posedge clk) begin
    if (ov_nxt && !ov_r || ov_nxt && !out_stall) begin
      fk_r    <= ent_r.kind;
      fch_r   <= ent_r.channel;
      fid_r   <= ent_r.id;
      flen_r  <= ent_r.length;
      fpay_r  <= ent_r.payload;
      ffd_r   <= (ent_r.kind == kind_a_r) || (ent_r.kind == kind_b_r);
      fsucc_r <= succ_nxt;
      fcnt_r  <= emit_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_is_frame      = res_frame_r;
  assign out_last          = res_last_r;
  assign out_out_kind      = res_frame_r ? fk_r : '0;
  assign out_out_channel   = res_frame_r ? fch_r : '0;
  assign out_out_id        = res_frame_r ? fid_r : '0;
  assign out_fd_flag       = res_frame_r && ffd_r;
  assign out_out_length    = res_frame_r ? flen_r : '0;
  assign out_out_payload   = res_frame_r ? fpay_r : '0;
  assign out_stamp         = res_frame_r ? stamp_r : '0;
  assign out_success       = res_frame_r ? 1'b0 : fsucc_r;
  assign out_emitted_count = res_frame_r ? '0 : fcnt_r;

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pfs_pkg::ST_IDLE) |-> in_stall)
    else $error("word taken while busy");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= TC_W'(MAX_TASKS))
    else $error("task count overflow");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(out_last) && $stable(out_is_frame) &&
                             $stable(out_out_id)))
    else $error("stalled word changed");
  a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= K_W'(MAX_CATCHUP))
    else $error("catch-up cap exceeded");

endmodule
